// ===== sv/bffa_pkg.sv =====
// Shared codes and field widths for the bitmap first-fit allocator.
package bffa_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int NUM_W   = 11;
    localparam int STAT_W  = 2;
    localparam int CFG_IX_W = 1;

    // Bitmap memory word
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;

    // Largest scan limit a pool size can produce, rounded down to 8
    localparam int SIZE_CAP = 2040;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_BLOCK_SIZE = 1'd0;
    localparam logic [CFG_IX_W-1:0] CFG_INODE_SIZE = 1'd1;

    // Register reset values
    localparam logic [NUM_W-1:0] BLOCK_SIZE_RST = 11'd128;
    localparam logic [NUM_W-1:0] INODE_SIZE_RST = 11'd32;

endpackage

// ===== sv/bitmap_first_fit_allocator_unit.sv =====
// Bitmap first-fit allocator: two pool bitmaps in one word memory plus used counters.
//
// One request is in flight at a time. Allocate-lowest reads the pool's bitmap one
// 32-bit word per cycle from word 0 until it finds a clear bit inside the scan limit
// or reaches the last word of the limit, which gives pool full.
// Allocate-number and free do one read-modify-write of one word; out-of-range
// numbers and invalid commands go straight to the finish state. The bitmap
// memory has a single read port. After reset the bitmap memory is cleared one word
// per cycle, both pool regions, with o_stall held high; configuration writes are
// taken throughout. A finished result waits in the output register while the block
// returns to accept the next item.
module bitmap_first_fit_allocator_unit
    import bffa_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic                i_pool,
    input  logic [NUM_W-1:0]    i_entry_number,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STAT_W-1:0]   o_status,
    output logic [NUM_W-1:0]    o_granted_number,
    output logic [NUM_W-1:0]    o_free_count,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [NUM_W-1:0]    i_cfg_data
);

    // Memory geometry
    localparam int NWORDS    = (ENTRIES + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int ADDR_W    = WORD_AW + 1;
    localparam int MEM_DEPTH = 2 << WORD_AW;
    localparam int CMP_W     = (WORD_AW > 6) ? WORD_AW : 6;
    localparam int ENT_CAP   = ((ENTRIES / 8) * 8 > SIZE_CAP) ? SIZE_CAP : (ENTRIES / 8) * 8;
    localparam logic [NUM_W-1:0] LIM_CAP = NUM_W'(ENT_CAP);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic                  r_pool;
    logic [CMD_W-1:0]      r_cmd;
    logic [WORD_AW-1:0]    r_word;
    logic [BIT_W-1:0]      r_bit;
    logic [5:0]            r_last_word;
    logic [BIT_W-1:0]      r_last_bit;
    logic [STAT_W-1:0]     r_res_status;
    logic [NUM_W-1:0]      r_res_grant;
    logic [NUM_W-1:0]      r_blocks_used;
    logic [NUM_W-1:0]      r_inodes_used;
    logic [NUM_W-1:0]      r_block_size;
    logic [NUM_W-1:0]      r_inode_size;
    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_out_status;
    logic [NUM_W-1:0]      r_out_grant;
    logic [NUM_W-1:0]      r_out_free;

    logic [WORD_W-1:0]     r_map_mem [MEM_DEPTH];
    logic [WORD_W-1:0]     r_rdata;

    logic                  accept;
    logic                  out_free;
    logic [NUM_W-1:0]      in_idx;
    logic                  in_bad;
    logic [NUM_W-1:0]      in_size;
    logic [NUM_W-1:0]      in_size8;
    logic [NUM_W-1:0]      in_lim;
    logic [NUM_W-1:0]      in_lim_m1;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic                  on_last;
    logic [WORD_W-1:0]     scan_mask;
    logic [WORD_W-1:0]     avail;
    logic                  found;
    logic [BIT_W-1:0]      found_bit;
    logic [WORD_W-1:0]     rmw_onehot;
    logic [NUM_W-1:0]      n_used;
    logic [NUM_W-1:0]      fin_used;
    logic [NUM_W-1:0]      fin_size;
    logic signed [NUM_W+1:0] fin_diff;
    logic [NUM_W-1:0]      fin_free;

    // Handshakes
    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // Request decode at accept
    assign in_idx    = i_entry_number - NUM_W'(1);
    assign in_bad    = (i_entry_number == '0) || (32'(i_entry_number) > ENTRIES);
    assign in_size   = i_pool ? r_inode_size : r_block_size;
    assign in_size8  = {in_size[NUM_W-1:3], 3'b000};
    assign in_lim    = (in_size8 > LIM_CAP) ? LIM_CAP : in_size8;
    assign in_lim_m1 = in_lim - NUM_W'(1);

    // Scan of the current word: clear bits inside the limit, lowest first
    always_comb begin
        on_last = (CMP_W'(r_word) == CMP_W'(r_last_word));
        for (int b = 0; b < WORD_W; b++) begin
            scan_mask[b] = !on_last || (BIT_W'(b) <= r_last_bit);
        end
        avail     = ~r_rdata & scan_mask;
        found     = |avail;
        found_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (avail[b]) begin
                found_bit = BIT_W'(b);
            end
        end
        rmw_onehot = WORD_W'(1) << r_bit;
    end

    // Memory port control
    always_comb begin
        rd_addr = {r_pool, r_word};
        mem_we  = 1'b0;
        wr_addr = {r_pool, r_word};
        wr_data = r_rdata;
        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            S_IDLE: begin
                if (i_command == CMD_ALLOC) begin
                    rd_addr = {i_pool, WORD_AW'(0)};
                end else begin
                    rd_addr = {i_pool, WORD_AW'(in_idx >> BIT_W)};
                end
            end
            S_SCAN: begin
                rd_addr = {r_pool, r_word + WORD_AW'(1)};
                if (found) begin
                    mem_we  = 1'b1;
                    wr_data = r_rdata | (WORD_W'(1) << found_bit);
                end
            end
            S_RMW: begin
                mem_we  = 1'b1;
                wr_data = (r_cmd == CMD_SET) ? (r_rdata | rmw_onehot)
                                             : (r_rdata & ~rmw_onehot);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_map_mem[rd_addr];
    end

    // Counter update and free count
    always_comb begin
        n_used   = r_pool ? r_inodes_used : r_blocks_used;
        if (r_state == S_RMW && r_cmd == CMD_FREE) begin
            n_used = n_used - NUM_W'(1);
        end else begin
            n_used = n_used + NUM_W'(1);
        end
        fin_used = r_pool ? r_inodes_used : r_blocks_used;
        fin_size = r_pool ? r_inode_size : r_block_size;
        fin_diff = $signed({2'b00, fin_size}) - (NUM_W+2)'($signed(fin_used));
        if (fin_diff < 0) begin
            fin_free = '0;
        end else if (fin_diff > $signed({2'b00, fin_size})) begin
            fin_free = fin_size;
        end else begin
            fin_free = fin_diff[NUM_W-1:0];
        end
    end

    // Control state machine and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_blocks_used <= '0;
            r_inodes_used <= '0;
            r_block_size  <= BLOCK_SIZE_RST;
            r_inode_size  <= INODE_SIZE_RST;
            r_out_valid   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BLOCK_SIZE) begin
                    r_block_size <= i_cfg_data;
                end else begin
                    r_inode_size <= i_cfg_data;
                end
            end
            // output drains; a finishing item reloads it below
            if (r_out_valid && !i_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_pool       <= i_pool;
                        r_cmd        <= i_command;
                        r_bit        <= in_idx[BIT_W-1:0];
                        r_last_word  <= in_lim_m1[NUM_W-1:BIT_W];
                        r_last_bit   <= in_lim_m1[BIT_W-1:0];
                        if (i_command == CMD_ALLOC) begin
                            r_word      <= '0;
                            r_res_grant <= '0;
                            if (in_lim == '0) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_FINISH;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if ((i_command == CMD_SET || i_command == CMD_FREE)
                                     && !in_bad) begin
                            r_word       <= WORD_AW'(in_idx >> BIT_W);
                            r_res_grant  <= i_entry_number;
                            r_res_status <= ST_OK;
                            r_state      <= S_RMW;
                        end else begin
                            r_res_grant  <= '0;
                            r_res_status <= ST_RANGE;
                            r_state      <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        if (r_pool) begin
                            r_inodes_used <= n_used;
                        end else begin
                            r_blocks_used <= n_used;
                        end
                        r_res_status <= ST_OK;
                        r_res_grant  <= NUM_W'({r_word, found_bit} + 1);
                        r_state      <= S_FINISH;
                    end else if (on_last) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_FINISH;
                    end else begin
                        r_word <= r_word + WORD_AW'(1);
                    end
                end
                S_RMW: begin
                    if (r_pool) begin
                        r_inodes_used <= n_used;
                    end else begin
                        r_blocks_used <= n_used;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_grant  <= r_res_grant;
                        r_out_free   <= fin_free;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_granted_number = r_out_grant;
    assign o_free_count     = r_out_free;

    // No request is taken while the bitmap is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_stall)
        else $error("request accepted during bitmap clear");

    // One request at a time: an accepted item closes the request channel
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second request accepted while one is in flight");

    // A grant is nonzero exactly when the status is ok
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_OK) == (o_granted_number != '0)))
        else $error("granted number disagrees with status");

    // The scan never walks past the stored words of a pool
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_word) < NWORDS))
        else $error("scan word beyond bitmap");

endmodule

// ===== verif/bitmap_first_fit_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap first-fit allocator unit: directed table, random phases.
module bitmap_first_fit_allocator_unit_tb
    import bffa_pkg::*;
();

    localparam int MAP_DEPTH   = 1024;     // ENTRIES of the instance
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int PHASE_ITEMS = 240;
    localparam int N_DIR       = 30;
    localparam int N_PHASES    = 6;
    localparam int TAIL_CYCLES = 100;
    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;  // unused command encoding

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NUM_W-1:0]  granted;
        logic [NUM_W-1:0]  free_cnt;
    } t_grant;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // directed row: a request, or a register write (pool = index, num = data)
    typedef struct packed {
        t_row_kind        kind;
        logic [CMD_W-1:0] cmd;
        logic             pool;
        logic [NUM_W-1:0] num;
        logic             typed;
        t_grant           exp;
    } t_dir_row;

    // random phase: pool sizes and command mix in percent (rest is invalid commands)
    typedef struct packed {
        logic [NUM_W-1:0] bsize;
        logic [NUM_W-1:0] isize;
        logic [7:0]       alloc_pct;
        logic [7:0]       set_pct;
        logic [7:0]       free_pct;
    } t_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [CMD_W-1:0]    i_command;
    logic                i_pool;
    logic [NUM_W-1:0]    i_entry_number;
    logic                o_valid;
    logic                i_stall;
    logic [STAT_W-1:0]   o_status;
    logic [NUM_W-1:0]    o_granted_number;
    logic [NUM_W-1:0]    o_free_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [NUM_W-1:0]    i_cfg_data;

    // shadow state of the allocator
    bit               pool_map  [0:1][0:MAP_DEPTH-1];
    logic [NUM_W-1:0] pool_used [0:1];
    logic [NUM_W-1:0] pool_size [0:1];
    t_grant           grant_q [$];

    int n_req, n_granted, n_full, n_range, n_cfg, n_results, n_err;
    int hold_seen;
    int tx_calm;
    bit hold_req;

    t_dir_row dir_tab [N_DIR] = '{
        // after reset: block size 128, inode size 32
        '{ROW_REQ, CMD_ALLOC, 1'b0, 11'd0,    1'b1, '{ST_OK,    11'd1,    11'd127}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd2047, 1'b1, '{ST_OK,    11'd1,    11'd31}},
        // top entry, above the pool size but inside the map
        '{ROW_REQ, CMD_SET,   1'b0, 11'd1024, 1'b1, '{ST_OK,    11'd1024, 11'd126}},
        '{ROW_REQ, CMD_FREE,  1'b0, 11'd1024, 1'b1, '{ST_OK,    11'd1024, 11'd127}},
        // out of range numbers and the invalid command
        '{ROW_REQ, CMD_SET,   1'b0, 11'd0,    1'b1, '{ST_RANGE, 11'd0,    11'd127}},
        '{ROW_REQ, CMD_FREE,  1'b1, 11'd1025, 1'b1, '{ST_RANGE, 11'd0,    11'd31}},
        '{ROW_REQ, CMD_SET,   1'b1, 11'd2047, 1'b1, '{ST_RANGE, 11'd0,    11'd31}},
        '{ROW_REQ, CMD_BAD,   1'b0, 11'd5,    1'b1, '{ST_RANGE, 11'd0,    11'd127}},
        // double free wraps the used counter below zero, free count clamps at size
        '{ROW_REQ, CMD_FREE,  1'b1, 11'd1,    1'b1, '{ST_OK,    11'd1,    11'd32}},
        '{ROW_REQ, CMD_FREE,  1'b1, 11'd1,    1'b1, '{ST_OK,    11'd1,    11'd32}},
        '{ROW_REQ, CMD_SET,   1'b1, 11'd1,    1'b1, '{ST_OK,    11'd1,    11'd32}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        // set of an entry already set still counts
        '{ROW_REQ, CMD_SET,   1'b1, 11'd2,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b0, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        // empty inode pool, then a size below one scan group
        '{ROW_CFG, CMD_ALLOC, CFG_INODE_SIZE, 11'd0, 1'b0, '{ST_OK, 11'd0, 11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b1, '{ST_FULL,  11'd0,    11'd0}},
        '{ROW_CFG, CMD_ALLOC, CFG_INODE_SIZE, 11'd7, 1'b0, '{ST_OK, 11'd0, 11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b1, '{ST_FULL,  11'd0,    11'd5}},
        // fill an 8-entry inode pool to the brim
        '{ROW_CFG, CMD_ALLOC, CFG_INODE_SIZE, 11'd8, 1'b0, '{ST_OK, 11'd0, 11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b1, 11'd0,    1'b1, '{ST_FULL,  11'd0,    11'd0}},
        // block pool beyond the map, scan limit clamps
        '{ROW_CFG, CMD_ALLOC, CFG_BLOCK_SIZE, 11'd2047, 1'b0, '{ST_OK, 11'd0, 11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b0, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}},
        '{ROW_CFG, CMD_ALLOC, CFG_BLOCK_SIZE, 11'd1024, 1'b0, '{ST_OK, 11'd0, 11'd0}},
        '{ROW_REQ, CMD_ALLOC, 1'b0, 11'd0,    1'b0, '{ST_OK,    11'd0,    11'd0}}
    };

    t_phase phase_tab [N_PHASES] = '{
        '{11'd1024, 11'd1024, 8'd50, 8'd25, 8'd20},
        '{11'd16,   11'd1,    8'd60, 8'd10, 8'd25},
        '{11'd2047, 11'd0,    8'd40, 8'd30, 8'd25},
        '{11'd64,   11'd40,   8'd30, 8'd15, 8'd50},
        '{11'd300,  11'd1023, 8'd55, 8'd25, 8'd15},
        '{11'd128,  11'd32,   8'd45, 8'd25, 8'd25}
    };

    bitmap_first_fit_allocator_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_pool           (i_pool),
        .i_entry_number   (i_entry_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_granted_number (o_granted_number),
        .o_free_count     (o_free_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // run limit
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", grant_q.size());
        $display("bitmap_first_fit_allocator_unit: mismatch");
        $finish;
    end

    // size minus used, used read as signed 11 bits, clamped to 0..size
    function automatic logic [NUM_W-1:0] free_entries(input int size, input logic [NUM_W-1:0] used);
        int u;
        int f;
        u = used;
        if (u >= 1024) u -= 2048;
        f = size - u;
        if (f < 0) f = 0;
        if (f > size) f = size;
        return NUM_W'(f);
    endfunction

    // apply one request to the shadow state and return its result
    function automatic t_grant predict_grant(input logic [CMD_W-1:0] cmd, input logic pool,
                                             input logic [NUM_W-1:0] num);
        t_grant r;
        int     size;
        int     lim;
        int     i;
        size = pool_size[pool];
        r.status  = ST_OK;
        r.granted = '0;
        case (cmd)
            CMD_ALLOC: begin
                lim = (size / 8) * 8;
                if (lim > MAP_DEPTH) lim = MAP_DEPTH;
                r.status = ST_FULL;
                for (i = 0; i < lim && r.status == ST_FULL; i++) begin
                    if (!pool_map[pool][i]) begin
                        pool_map[pool][i] = 1'b1;
                        pool_used[pool]   = pool_used[pool] + 1'b1;
                        r.granted = NUM_W'(i + 1);
                        r.status  = ST_OK;
                    end
                end
            end
            CMD_SET, CMD_FREE: begin
                if (num == 0 || num > MAP_DEPTH) begin
                    r.status = ST_RANGE;
                end else begin
                    // counter moves whatever the old bit was
                    pool_map[pool][num-1] = (cmd == CMD_SET);
                    pool_used[pool] = (cmd == CMD_SET) ? pool_used[pool] + 1'b1
                                                       : pool_used[pool] - 1'b1;
                    r.granted = num;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.free_cnt = free_entries(size, pool_used[pool]);
        return r;
    endfunction

    // sender idle: mostly none, some short, a few long, with calm stretches
    function automatic int pick_gap();
        int r;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            tx_calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // entry number: mostly inside the pool, some edges, some anything
    function automatic logic [NUM_W-1:0] pick_number(input logic pool);
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = pool_size[pool];
        if (top > MAP_DEPTH) top = MAP_DEPTH;
        if (top < 1) top = 1;
        if (r < 8) return NUM_W'($urandom_range(0, 2047));
        if (r < 14) begin
            case ($urandom_range(0, 4))
                0: return 11'd0;
                1: return 11'd1;
                2: return 11'd1024;
                3: return 11'd1025;
                default: return 11'd2047;
            endcase
        end
        return NUM_W'($urandom_range(1, top));
    endfunction

    // offer one request, wait for it to be taken, then predict it
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic pool, input logic [NUM_W-1:0] num,
                         input int gap, input logic typed, input t_grant exp);
        t_grant pred;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_pool         <= pool;
        i_entry_number <= num;
        do @(posedge i_clk); while (o_stall);
        pred = predict_grant(cmd, pool, num);
        grant_q.push_back(typed ? exp : pred);
        n_req++;
        case (pred.status)
            ST_OK:    n_granted++;
            ST_FULL:  n_full++;
            default:  n_range++;
        endcase
    endtask

    // register write on the config channel
    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [NUM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pool_size[idx] = data;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall stretches, plus one long hold-off on request
    initial begin : result_stall
        int   rx_left;
        int   r;
        logic rx_level;
        rx_left  = 0;
        rx_level = 1'b0;
        i_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_seen++;
                rx_level  = 1'b1;
                rx_left   = HOLD_CYCLES;
            end else if (rx_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    rx_level = 1'b0;
                    rx_left  = $urandom_range(1, 30);
                end else if (r < 90) begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(1, 3);
                end else begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(10, 60);
                end
            end
            i_stall <= rx_level;
            rx_left--;
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_grant want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (grant_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected item: status %0d granted %0d free %0d",
                         $time, o_status, o_granted_number, o_free_count);
            end else begin
                want = grant_q.pop_front();
                if (o_status !== want.status) begin
                    n_err++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                end
                if (o_granted_number !== want.granted) begin
                    n_err++;
                    $display("%0t: granted_number expected %0d actual %0d",
                             $time, want.granted, o_granted_number);
                end
                if (o_free_count !== want.free_cnt) begin
                    n_err++;
                    $display("%0t: free_count expected %0d actual %0d",
                             $time, want.free_cnt, o_free_count);
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_grant           none;
        t_phase           ph;
        int               k;
        int               p;
        int               r;
        logic             pool;
        logic [CMD_W-1:0] cmd;

        none           = '0;
        hold_req       = 1'b0;
        tx_calm        = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_ALLOC;
        i_pool         = 1'b0;
        i_entry_number = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_BLOCK_SIZE;
        i_cfg_data     = '0;
        pool_size[0]   = BLOCK_SIZE_RST;
        pool_size[1]   = INODE_SIZE_RST;
        pool_used[0]   = '0;
        pool_used[1]   = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (k = 0; k < N_DIR; k++) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[k].pool, dir_tab[k].num);
            end else begin
                issue(dir_tab[k].cmd, dir_tab[k].pool, dir_tab[k].num, pick_gap(),
                      dir_tab[k].typed, dir_tab[k].exp);
            end
        end

        // random phases, one pool-size setting each
        for (p = 0; p < N_PHASES; p++) begin
            ph = phase_tab[p];
            settle();
            write_reg(CFG_BLOCK_SIZE, ph.bsize);
            write_reg(CFG_INODE_SIZE, ph.isize);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // long receiver hold-off while requests keep coming
                if (p == 1 && k == 40) hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < ph.alloc_pct) cmd = CMD_ALLOC;
                else if (r < ph.alloc_pct + ph.set_pct) cmd = CMD_SET;
                else if (r < ph.alloc_pct + ph.set_pct + ph.free_pct) cmd = CMD_FREE;
                else cmd = CMD_BAD;
                pool = $urandom_range(0, 1);
                issue(cmd, pool, pick_number(pool), pick_gap(), 1'b0, none);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d granted, %0d pool full, %0d out of range or invalid;",
                 n_req, n_granted, n_full, n_range);
        $display("%0d register writes over %0d size settings, %0d results checked, %0d hold-off(s)",
                 n_cfg, N_PHASES, n_results, hold_seen);
        if (n_err == 0) begin
            $display("bitmap_first_fit_allocator_unit: match");
        end else begin
            $display("bitmap_first_fit_allocator_unit: mismatch");
        end
        $finish;
    end

endmodule
